// File: sv/xxh_pkg.sv
// shared constants and types for the xxh64 stream hash
`default_nettype none
package xxh_pkg;
    localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] P3 = 64'h165667B19E3779F9;
    localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

    // seed register, byte address 0
    localparam logic ADDR_SEED = 1'b0;

    // datapath operations
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;  // latch input word, bump length
    localparam logic [3:0] OP_RMUL    = 4'd2;  // t = buf[sel] or lane[sel] times P2
    localparam logic [3:0] OP_RROT    = 4'd3;  // t = rotl(acc + t, 31)
    localparam logic [3:0] OP_RFIN    = 4'd4;  // acc = t * P1 (lane update), else t = t * P1
    localparam logic [3:0] OP_HINIT   = 4'd5;  // h = lane sum or seed + P5
    localparam logic [3:0] OP_MXOR    = 4'd6;  // h ^= t (t = round(0,x))
    localparam logic [3:0] OP_MFIN    = 4'd7;  // h = h * P1 + P4
    localparam logic [3:0] OP_ADDLEN  = 4'd8;  // h += total length
    localparam logic [3:0] OP_T8FIN   = 4'd9;  // h = rotl(h,27) * P1 + P4
    localparam logic [3:0] OP_T4      = 4'd10; // h ^= lo32 * P1; h = rotl(h,23)*P2+P3
    localparam logic [3:0] OP_T1      = 4'd11; // h ^= byte * P5; h = rotl(h,11)*P1
    localparam logic [3:0] OP_AVAL    = 4'd12; // one avalanche step
    localparam logic [3:0] OP_REARM   = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] sel;    // lane / buffer index
        logic [1:0] sub;    // sub step inside an op
        logic       src_buf; // RMUL: 1 buffer, 0 lane accumulator; RROT: 1 adds lane
        logic       pre;    // partial product cycle of a multiply, no state update
    } t_cmd;

    typedef struct packed {
        logic       last;
        logic [3:0] nbytes;
        logic [1:0] nbuf;
        logic       seen;
    } t_stat;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction
endpackage
`default_nettype wire

// File: sv/xxh_datapath.sv
// datapath: lanes, stripe buffer, length, hash register and one multiplier
`default_nettype none
module xxh_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire xxh_pkg::t_cmd   i_cmd,
    input  wire logic [63:0]     i_seed,
    input  wire logic [63:0]     i_data_word,
    input  wire logic [3:0]      i_byte_count,
    input  wire logic            i_last,
    output xxh_pkg::t_stat       o_stat,
    output logic [63:0]          o_hash
);
    logic [63:0] r_lane [4];
    logic [63:0] r_buf [4];
    logic [63:0] r_w, r_t, r_h, r_len;
    logic [3:0]  r_n;
    logic        r_last, r_seen;
    logic [1:0]  r_nbuf;
    logic [63:0] r_pp_ll;
    logic [31:0] r_pp_x;
    logic [63:0] n_mul_a, n_mul_b, n_prod, n_sum;
    logic [63:0] n_pp_ll;
    logic [31:0] n_pp_x;
    logic [3:0]  n_cnt;
    logic [63:0] n_wmask;

    always_comb begin
        n_cnt = (!i_last || i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
        n_wmask = (n_cnt == 4'd8) ? i_data_word
                : i_data_word & ((64'd1 << {n_cnt, 3'b000}) - 64'd1);
    end

    // 64x64 low product: 32x32 partial products are registered, then summed
    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        unique case (i_cmd.op) inside
            xxh_pkg::OP_RMUL: begin
                n_mul_a = i_cmd.src_buf ? r_buf[i_cmd.sel] : r_lane[i_cmd.sel];
                n_mul_b = xxh_pkg::P2;
            end
            xxh_pkg::OP_RFIN, xxh_pkg::OP_MFIN, xxh_pkg::OP_T8FIN: begin
                n_mul_a = (i_cmd.op == xxh_pkg::OP_RFIN) ? r_t : r_h;
                n_mul_b = xxh_pkg::P1;
            end
            xxh_pkg::OP_T4: begin
                n_mul_a = (i_cmd.sub == 2'd0) ? {32'd0, r_w[31:0]} : r_h;
                n_mul_b = (i_cmd.sub == 2'd0) ? xxh_pkg::P1 : xxh_pkg::P2;
            end
            xxh_pkg::OP_T1: begin
                n_mul_a = (i_cmd.sub == 2'd0) ? {56'd0, r_w[7:0]} : r_h;
                n_mul_b = (i_cmd.sub == 2'd0) ? xxh_pkg::P5 : xxh_pkg::P1;
            end
            xxh_pkg::OP_AVAL: begin
                n_mul_a = r_h;
                n_mul_b = i_cmd.sub[1] ? xxh_pkg::P3 : xxh_pkg::P2;
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
        n_pp_ll = {32'd0, n_mul_a[31:0]} * {32'd0, n_mul_b[31:0]};
        n_pp_x = n_mul_a[31:0] * n_mul_b[63:32] + n_mul_a[63:32] * n_mul_b[31:0];
        n_prod = r_pp_ll + {r_pp_x, 32'd0};
        n_sum = xxh_pkg::rotl(r_lane[0], 1) + xxh_pkg::rotl(r_lane[1], 7)
              + xxh_pkg::rotl(r_lane[2], 12) + xxh_pkg::rotl(r_lane[3], 18);
    end

    always_ff @(posedge i_clk) begin
        r_pp_ll <= n_pp_ll;
        r_pp_x  <= n_pp_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nbuf <= '0;
            r_seen <= 1'b0;
            r_len  <= '0;
            r_last <= 1'b0;
            r_n    <= '0;
            r_lane[0] <= xxh_pkg::P1 + xxh_pkg::P2;
            r_lane[1] <= xxh_pkg::P2;
            r_lane[2] <= '0;
            r_lane[3] <= '0 - xxh_pkg::P1;
        end else if (!i_cmd.pre) begin
            unique case (i_cmd.op)
                xxh_pkg::OP_LOAD: begin
                    r_w    <= n_wmask;
                    r_n    <= n_cnt;
                    r_last <= i_last;
                    r_len  <= r_len + {60'd0, n_cnt};
                    if (n_cnt == 4'd8) begin
                        r_buf[r_nbuf] <= n_wmask;
                        r_nbuf <= r_nbuf + 2'd1;
                        if (r_nbuf == 2'd3 && !r_seen) begin
                            r_lane[0] <= i_seed + xxh_pkg::P1 + xxh_pkg::P2;
                            r_lane[1] <= i_seed + xxh_pkg::P2;
                            r_lane[2] <= i_seed;
                            r_lane[3] <= i_seed - xxh_pkg::P1;
                        end
                    end
                end
                xxh_pkg::OP_RMUL: r_t <= n_prod;
                xxh_pkg::OP_RROT: begin
                    r_t <= xxh_pkg::rotl((i_cmd.src_buf ? r_lane[i_cmd.sel] : 64'd0)
                                         + r_t, 31);
                end
                xxh_pkg::OP_RFIN: begin
                    if (i_cmd.src_buf && i_cmd.sub == 2'd0) begin
                        r_lane[i_cmd.sel] <= n_prod;
                        if (i_cmd.sel == 2'd3) r_seen <= 1'b1;
                    end else begin
                        r_t <= n_prod;
                    end
                end
                xxh_pkg::OP_HINIT:
                    r_h <= r_seen ? n_sum : i_seed + xxh_pkg::P5;
                xxh_pkg::OP_MXOR:  r_h <= r_h ^ r_t;
                xxh_pkg::OP_MFIN:  r_h <= n_prod + xxh_pkg::P4;
                xxh_pkg::OP_ADDLEN: r_h <= r_h + r_len;
                xxh_pkg::OP_T8FIN: begin
                    if (i_cmd.sub == 2'd0) r_h <= xxh_pkg::rotl(r_h, 27);
                    else r_h <= n_prod + xxh_pkg::P4;
                end
                xxh_pkg::OP_T4: begin
                    unique case (i_cmd.sub)
                        2'd0: r_h <= r_h ^ n_prod;
                        2'd1: r_h <= xxh_pkg::rotl(r_h, 23);
                        default: begin
                            r_h <= n_prod + xxh_pkg::P3;
                            r_w <= r_w >> 32;
                            r_n <= r_n - 4'd4;
                        end
                    endcase
                end
                xxh_pkg::OP_T1: begin
                    unique case (i_cmd.sub)
                        2'd0: r_h <= r_h ^ n_prod;
                        2'd1: r_h <= xxh_pkg::rotl(r_h, 11);
                        default: begin
                            r_h <= n_prod;
                            r_w <= r_w >> 8;
                            r_n <= r_n - 4'd1;
                        end
                    endcase
                end
                xxh_pkg::OP_AVAL: begin
                    // sub 0,2: xor shift; 1,3: multiply; final xor in controller seq
                    unique case (i_cmd.sub)
                        2'd0: r_h <= r_h ^ (r_h >> 33);
                        2'd1: r_h <= i_cmd.src_buf ? (r_h ^ (r_h >> 32)) : n_prod;
                        2'd2: r_h <= r_h ^ (r_h >> 29);
                        default: r_h <= n_prod;
                    endcase
                end
                xxh_pkg::OP_REARM: begin
                    r_nbuf <= '0;
                    r_seen <= 1'b0;
                    r_len  <= '0;
                    r_lane[0] <= i_seed + xxh_pkg::P1 + xxh_pkg::P2;
                    r_lane[1] <= i_seed + xxh_pkg::P2;
                    r_lane[2] <= i_seed;
                    r_lane[3] <= i_seed - xxh_pkg::P1;
                end
                default: ;
            endcase
        end
    end

    assign o_stat = '{last: r_last, nbytes: r_n, nbuf: r_nbuf, seen: r_seen};
    assign o_hash = r_h;
endmodule
`default_nettype wire

// File: sv/xxh_ctrl.sv
// controller: sequences rounds, merge, tail and avalanche steps
`default_nettype none
module xxh_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire xxh_pkg::t_stat i_stat,
    output xxh_pkg::t_cmd      o_cmd,
    output logic               o_valid,
    input  wire logic          i_stall
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_LRND  = 4'd2;  // lane rounds
    localparam logic [3:0] S_HINIT = 4'd3;
    localparam logic [3:0] S_MERGE = 4'd4;
    localparam logic [3:0] S_LEN   = 4'd5;
    localparam logic [3:0] S_T8    = 4'd6;
    localparam logic [3:0] S_T4    = 4'd7;
    localparam logic [3:0] S_T1    = 4'd8;
    localparam logic [3:0] S_AVAL  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_TCHK  = 4'd11;

    logic [3:0] r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic [2:0] r_step, n_step;
    logic [1:0] r_bidx, n_bidx;
    logic       r_valid, n_valid;
    logic       r_mwait, n_mwait;
    logic       w_mul_use;

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_step = r_step;
        n_bidx = r_bidx;
        n_valid = r_valid;
        o_cmd = '{op: xxh_pkg::OP_NONE, sel: r_idx, sub: r_step[1:0], src_buf: 1'b0,
                  pre: 1'b0};
        unique case (r_state) inside
            S_IDLE: begin
                if (i_valid && !r_valid) begin
                    o_cmd.op = xxh_pkg::OP_LOAD;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_idx = '0;
                n_step = '0;
                n_bidx = '0;
                // buffer wrapped to zero after a full word: stripe complete
                if (i_stat.nbytes == 4'd8 && i_stat.nbuf == 2'd0) n_state = S_LRND;
                else if (i_stat.last) n_state = S_HINIT;
                else n_state = S_IDLE;
            end
            S_LRND: begin
                o_cmd.src_buf = 1'b1;
                o_cmd.sub = 2'd0;
                o_cmd.op = (r_step == 3'd0) ? xxh_pkg::OP_RMUL
                         : (r_step == 3'd1) ? xxh_pkg::OP_RROT : xxh_pkg::OP_RFIN;
                n_step = (r_step == 3'd2) ? 3'd0 : r_step + 3'd1;
                if (r_step == 3'd2) begin
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3) n_state = i_stat.last ? S_HINIT : S_IDLE;
                end
            end
            S_HINIT: begin
                o_cmd.op = xxh_pkg::OP_HINIT;
                n_idx = '0;
                n_step = '0;
                n_state = i_stat.seen ? S_MERGE : S_LEN;
            end
            S_MERGE: begin
                // round(0, lane) then h ^= ; h = h*P1+P4
                unique case (r_step)
                    3'd0: o_cmd.op = xxh_pkg::OP_RMUL;
                    3'd1: o_cmd.op = xxh_pkg::OP_RROT;
                    3'd2: begin
                        o_cmd.op = xxh_pkg::OP_RFIN;
                        o_cmd.sub = 2'd1;
                    end
                    3'd3: o_cmd.op = xxh_pkg::OP_MXOR;
                    default: o_cmd.op = xxh_pkg::OP_MFIN;
                endcase
                n_step = (r_step == 3'd4) ? 3'd0 : r_step + 3'd1;
                if (r_step == 3'd4) begin
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3) n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.op = xxh_pkg::OP_ADDLEN;
                n_step = '0;
                n_bidx = '0;
                n_state = S_TCHK;
            end
            S_TCHK: begin
                n_step = '0;
                if (r_bidx != i_stat.nbuf) n_state = S_T8;
                else if (i_stat.nbytes >= 4'd4 && i_stat.nbytes != 4'd8) n_state = S_T4;
                else if (i_stat.nbytes != 4'd0 && i_stat.nbytes != 4'd8) n_state = S_T1;
                else n_state = S_AVAL;
            end
            S_T8: begin
                o_cmd.sel = r_bidx;
                o_cmd.src_buf = 1'b1;
                unique case (r_step)
                    3'd0: o_cmd.op = xxh_pkg::OP_RMUL;
                    3'd1: begin
                        o_cmd.op = xxh_pkg::OP_RROT;
                        o_cmd.src_buf = 1'b0;
                    end
                    3'd2: begin
                        o_cmd.op = xxh_pkg::OP_RFIN;
                        o_cmd.sub = 2'd1;
                    end
                    3'd3: o_cmd.op = xxh_pkg::OP_MXOR;
                    3'd4: begin
                        o_cmd.op = xxh_pkg::OP_T8FIN;
                        o_cmd.sub = 2'd0;
                    end
                    default: begin
                        o_cmd.op = xxh_pkg::OP_T8FIN;
                        o_cmd.sub = 2'd1;
                    end
                endcase
                n_step = (r_step == 3'd5) ? 3'd0 : r_step + 3'd1;
                if (r_step == 3'd5) begin
                    n_bidx = r_bidx + 2'd1;
                    n_state = S_TCHK;
                end
            end
            S_T4, S_T1: begin
                o_cmd.op = (r_state == S_T4) ? xxh_pkg::OP_T4 : xxh_pkg::OP_T1;
                n_step = (r_step == 3'd2) ? 3'd0 : r_step + 3'd1;
                if (r_step == 3'd2) n_state = S_TCHK;
            end
            S_AVAL: begin
                o_cmd.op = xxh_pkg::OP_AVAL;
                unique case (r_step)
                    3'd0: o_cmd.sub = 2'd0;
                    3'd1: o_cmd.sub = 2'd1;
                    3'd2: o_cmd.sub = 2'd2;
                    3'd3: o_cmd.sub = 2'd3;
                    default: begin
                        o_cmd.sub = 2'd1;
                        o_cmd.src_buf = 1'b1;
                    end
                endcase
                // sub 1 multiplies by P2, sub 3 by P3; last step is the xor shift by 32
                n_step = r_step + 3'd1;
                if (r_step == 3'd4) n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.op = xxh_pkg::OP_REARM;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        w_mul_use = (o_cmd.op == xxh_pkg::OP_RMUL) || (o_cmd.op == xxh_pkg::OP_RFIN)
                 || (o_cmd.op == xxh_pkg::OP_MFIN)
                 || (o_cmd.op == xxh_pkg::OP_T8FIN && o_cmd.sub == 2'd1)
                 || ((o_cmd.op == xxh_pkg::OP_T4 || o_cmd.op == xxh_pkg::OP_T1)
                     && !o_cmd.sub[0])
                 || (o_cmd.op == xxh_pkg::OP_AVAL && o_cmd.sub[0] && !o_cmd.src_buf);
        // a multiply step is held while the partial products are registered (pre, no state update)
        n_mwait = w_mul_use && !r_mwait;
        if (n_mwait) begin
            o_cmd.pre = 1'b1;
            n_state = r_state;
            n_idx = r_idx;
            n_step = r_step;
            n_bidx = r_bidx;
        end
        if (r_valid && !i_stall) n_valid = (r_state == S_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
            r_step <= '0;
            r_bidx <= '0;
            r_valid <= 1'b0;
            r_mwait <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_step <= n_step;
            r_bidx <= n_bidx;
            r_valid <= n_valid;
            r_mwait <= n_mwait;
        end
    end

    assign o_stall = (r_state != S_IDLE) || r_valid;
    assign o_valid = r_valid;
endmodule
`default_nettype wire

// File: sv/xxh64_stream_hash.sv
// top level: xxh64 stream hash with apb seed register
// per word: load, then check; a word that completes a 32-byte stripe adds the four lane rounds
// last word: result valid after the merge, tail steps and avalanche
// a new word is taken only while idle; each 64x64 multiply first registers its partial products
// result held in an output register until taken; input stalled while it waits
// reset (synchronous, active low): seed 0, lanes seeded, counts and length cleared
`default_nettype none
module xxh64_stream_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_data_word,
    input  wire logic [3:0]  i_byte_count,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_hash_value
);
    logic [63:0]    r_seed;
    xxh_pkg::t_cmd  w_cmd;
    xxh_pkg::t_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && paddr == xxh_pkg::ADDR_SEED) begin
            r_seed <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == xxh_pkg::ADDR_SEED) ? r_seed : 64'd0;

    xxh_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_stat(w_stat),
        .o_cmd(w_cmd), .o_valid, .i_stall
    );

    xxh_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_seed(r_seed), .i_data_word,
        .i_byte_count, .i_last, .o_stat(w_stat), .o_hash(o_hash_value)
    );
endmodule
`default_nettype wire
